[src/akf_pkg.sv]
// Package for the angle Kalman fusion block: sequencer codes, unit command and
// response structs, register map and saturation helper. No dependencies.
package akf_pkg;

   localparam int CfgAddrBits = 4;
   localparam int DivIters = 62;

   localparam logic [30:0] QaReset = 31'd2147484;
   localparam logic [30:0] QbReset = 31'd2147484;
   localparam logic [30:0] RReset = 31'd536870912;
   localparam logic [30:0] DtReset = 31'd10737418;
   localparam logic signed [31:0] OneQ30 = 32'sd1073741824;

   typedef enum logic [1:0] {
      REG_QA = 2'd0,
      REG_QB = 2'd1,
      REG_R  = 2'd2,
      REG_DT = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      SQ_IDLE,
      SQ_ISSUE,
      SQ_WAIT,
      SQ_DONE
   } seq_state_type;

   typedef enum logic [3:0] {
      ST_ANGLE_PRED,
      ST_P00_PRED,
      ST_P01_PRED,
      ST_P10_PRED,
      ST_P11_PRED,
      ST_GAIN0,
      ST_GAIN1,
      ST_C00,
      ST_C01,
      ST_C10,
      ST_C11,
      ST_BIAS,
      ST_ANGLE
   } step_type;

   typedef enum logic [1:0] {
      MP_IDLE,
      MP_LO,
      MP_HI,
      MP_SUM
   } mul_phase_type;

   typedef struct packed {
      logic               start;
      logic               sub;
      logic signed [34:0] op_a;
      logic signed [31:0] op_b;
      logic signed [31:0] base;
   } mul_cmd_type;

   typedef struct packed {
      logic               start;
      logic signed [31:0] num;
      logic signed [32:0] den;
   } div_cmd_type;

   typedef struct packed {
      logic               done;
      logic signed [31:0] result;
   } unit_rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      logic signed [31:0] r;
      if (v > 40'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -40'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

[src/akf_mul.sv]
// Shared multiply unit: result = sat32(base +/- round(a * b / 2^30)).
// One 35x17 multiplier is used twice per operation. Depends on akf_pkg.
module akf_mul
   import akf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  mul_cmd_type  cmd,
   output unit_rsp_type rsp
);

   mul_phase_type      phase_ff, phase_in;
   logic               done_ff, done_in;
   logic signed [34:0] a_ff, a_in;
   logic signed [31:0] b_ff, b_in;
   logic signed [31:0] base_ff, base_in;
   logic               sub_ff, sub_in;
   logic signed [51:0] lo_ff, lo_in;
   logic signed [51:0] hi_ff, hi_in;
   logic signed [31:0] result_ff, result_in;

   logic signed [16:0] chunk;
   logic signed [51:0] prod;
   logic signed [67:0] acc;
   logic signed [37:0] rq;
   logic signed [39:0] sum;

   // The low half of b is unsigned, the high half carries the sign.
   assign chunk = (phase_ff == MP_LO) ? $signed({1'b0, b_ff[15:0]})
                                      : $signed({b_ff[31], b_ff[31:16]});
   assign prod = a_ff * chunk;

   always_comb begin
      acc = $signed({hi_ff, 16'b0}) + $signed({{16{lo_ff[51]}}, lo_ff})
            + 68'sd536870912;
      rq = acc[67:30];
      if (sub_ff) begin
         sum = $signed({{8{base_ff[31]}}, base_ff}) - $signed({{2{rq[37]}}, rq});
      end else begin
         sum = $signed({{8{base_ff[31]}}, base_ff}) + $signed({{2{rq[37]}}, rq});
      end
   end

   always_comb begin
      phase_in = phase_ff;
      done_in = 1'b0;
      a_in = a_ff;
      b_in = b_ff;
      base_in = base_ff;
      sub_in = sub_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      result_in = result_ff;
      case (phase_ff)
         MP_IDLE: begin
            if (cmd.start) begin
               a_in = cmd.op_a;
               b_in = cmd.op_b;
               base_in = cmd.base;
               sub_in = cmd.sub;
               phase_in = MP_LO;
            end
         end
         MP_LO: begin
            lo_in = prod;
            phase_in = MP_HI;
         end
         MP_HI: begin
            hi_in = prod;
            phase_in = MP_SUM;
         end
         MP_SUM: begin
            result_in = sat32(sum);
            done_in = 1'b1;
            phase_in = MP_IDLE;
         end
         default: begin
            phase_in = MP_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= MP_IDLE;
         done_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      base_ff <= base_in;
      sub_ff <= sub_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      result_ff <= result_in;
   end

   assign rsp.done = done_ff;
   assign rsp.result = result_ff;

endmodule

[src/akf_div.sv]
// Serial gain divider: sat32(trunc(num * 2^30 / den)), zero when den is zero.
// Restoring division, one quotient bit per cycle. Depends on akf_pkg.
module akf_div
   import akf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  div_cmd_type  cmd,
   output unit_rsp_type rsp
);

   logic               busy_ff, busy_in;
   logic               fin_ff, fin_in;
   logic               done_ff, done_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic [61:0]        dvd_ff, dvd_in;
   logic [61:0]        quo_ff, quo_in;
   logic [33:0]        rem_ff, rem_in;
   logic [32:0]        dmag_ff, dmag_in;
   logic               neg_ff, neg_in;
   logic               zero_ff, zero_in;
   logic signed [31:0] result_ff, result_in;

   logic [32:0] nmag;
   logic [33:0] rem_sh;
   logic        ge;

   assign nmag = cmd.num[31] ? 33'(-$signed({cmd.num[31], cmd.num}))
                             : {1'b0, cmd.num};
   assign rem_sh = {rem_ff[32:0], dvd_ff[61]};
   assign ge = rem_sh >= {1'b0, dmag_ff};

   always_comb begin
      busy_in = busy_ff;
      fin_in = 1'b0;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      dvd_in = dvd_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      dmag_in = dmag_ff;
      neg_in = neg_ff;
      zero_in = zero_ff;
      result_in = result_ff;
      if (cmd.start && !busy_ff && !fin_ff) begin
         busy_in = 1'b1;
         cnt_in = '0;
         dvd_in = {nmag[31:0], 30'b0};
         quo_in = '0;
         rem_in = '0;
         dmag_in = cmd.den[32] ? 33'(-cmd.den) : cmd.den[32:0];
         neg_in = cmd.num[31] ^ cmd.den[32];
         zero_in = (cmd.den == '0);
      end else if (busy_ff) begin
         rem_in = ge ? rem_sh - {1'b0, dmag_ff} : rem_sh;
         quo_in = {quo_ff[60:0], ge};
         dvd_in = {dvd_ff[60:0], 1'b0};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(DivIters - 1)) begin
            busy_in = 1'b0;
            fin_in = 1'b1;
         end
      end else if (fin_ff) begin
         done_in = 1'b1;
         if (zero_ff) begin
            result_in = '0;
         end else if (neg_ff) begin
            if (quo_ff > 62'd2147483648) begin
               result_in = 32'sh80000000;
            end else begin
               result_in = 32'(-$signed({1'b0, quo_ff[31:0]}));
            end
         end else if (quo_ff > 62'd2147483647) begin
            result_in = 32'sh7fffffff;
         end else begin
            result_in = quo_ff[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         fin_ff <= fin_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dmag_ff <= dmag_in;
      neg_ff <= neg_in;
      zero_ff <= zero_in;
      result_ff <= result_in;
   end

   assign rsp.done = done_ff;
   assign rsp.result = result_ff;

endmodule

[src/angle_kalman_fusion_top.sv]
// One request at a time: each accepted request runs two gain divisions and eleven
// shared multiplies in sequence, then waits in the done state until the result side
// is free, and only then does the block accept the next request.
// Synchronous active-high reset clears the state to angle 0, bias 0, identity
// covariance, and loads the default noise and time-step registers.
// Sequencer, state and config registers; uses akf_pkg, akf_mul and akf_div.
module angle_kalman_fusion_top
   import akf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [63:0]            req_tdata,  // [31:0] accel_angle, [63:32] gyro_rate
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [63:0]            rsp_tdata,  // [31:0] fused_angle, [63:32] fused_rate
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CfgAddrBits-1:0] csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   seq_state_type state_ff, state_in;
   step_type      step_ff, step_in;

   logic [30:0] qa_ff, qb_ff, r_ff, dt_ff;

   logic signed [31:0] accel_ff, accel_in, gyro_ff, gyro_in;
   logic signed [31:0] angle_ff, angle_in, bias_ff, bias_in;
   logic signed [31:0] c00_ff, c00_in, c01_ff, c01_in, c10_ff, c10_in, c11_ff, c11_in;
   logic signed [31:0] p00_ff, p00_in, p01_ff, p01_in, p10_ff, p10_in, p11_ff, p11_in;
   logic signed [31:0] k0_ff, k0_in, k1_ff, k1_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [63:0]        rsp_tdata_ff, rsp_tdata_in;

   mul_cmd_type  mul_cmd;
   div_cmd_type  div_cmd;
   unit_rsp_type mul_rsp, div_rsp;

   logic               is_div, unit_done;
   logic signed [34:0] err;
   logic signed [31:0] rate;
   logic               csr_write;
   reg_index_type      csr_index;

   akf_mul u_mul (.clock(clock), .reset(reset), .cmd(mul_cmd), .rsp(mul_rsp));
   akf_div u_div (.clock(clock), .reset(reset), .cmd(div_cmd), .rsp(div_rsp));

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign csr_index = reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      case (csr_index)
         REG_QA:  csr_prdata = {1'b0, qa_ff};
         REG_QB:  csr_prdata = {1'b0, qb_ff};
         REG_R:   csr_prdata = {1'b0, r_ff};
         REG_DT:  csr_prdata = {1'b0, dt_ff};
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qa_ff <= QaReset;
         qb_ff <= QbReset;
         r_ff <= RReset;
         dt_ff <= DtReset;
      end else if (csr_write) begin
         case (csr_index)
            REG_QA:  qa_ff <= csr_pwdata[30:0];
            REG_QB:  qb_ff <= csr_pwdata[30:0];
            REG_R:   r_ff <= csr_pwdata[30:0];
            REG_DT:  dt_ff <= csr_pwdata[30:0];
            default: qa_ff <= qa_ff;
         endcase
      end
   end

   // Innovation uses the predicted angle; the bias step runs before the angle step.
   assign err = $signed({{3{accel_ff[31]}}, accel_ff}) - $signed({{3{angle_ff[31]}}, angle_ff});
   assign rate = sat32($signed({{8{gyro_ff[31]}}, gyro_ff})
                       - $signed({{8{bias_ff[31]}}, bias_ff}));
   assign is_div = (step_ff == ST_GAIN0) || (step_ff == ST_GAIN1);
   assign unit_done = is_div ? div_rsp.done : mul_rsp.done;

   // Operand selection for the shared units.
   always_comb begin
      mul_cmd.start = (state_ff == SQ_ISSUE) && !is_div;
      mul_cmd.sub = 1'b0;
      mul_cmd.op_a = '0;
      mul_cmd.op_b = $signed({1'b0, dt_ff});
      mul_cmd.base = '0;
      case (step_ff)
         ST_ANGLE_PRED: begin
            mul_cmd.op_a = $signed({{3{gyro_ff[31]}}, gyro_ff})
                           - $signed({{3{bias_ff[31]}}, bias_ff});
            mul_cmd.base = angle_ff;
         end
         ST_P00_PRED: begin
            mul_cmd.op_a = $signed({4'b0, qa_ff}) - $signed({{3{c01_ff[31]}}, c01_ff})
                           - $signed({{3{c10_ff[31]}}, c10_ff});
            mul_cmd.base = c00_ff;
         end
         ST_P01_PRED: begin
            mul_cmd.op_a = $signed({{3{c11_ff[31]}}, c11_ff});
            mul_cmd.base = c01_ff;
            mul_cmd.sub = 1'b1;
         end
         ST_P10_PRED: begin
            mul_cmd.op_a = $signed({{3{c11_ff[31]}}, c11_ff});
            mul_cmd.base = c10_ff;
            mul_cmd.sub = 1'b1;
         end
         ST_P11_PRED: begin
            mul_cmd.op_a = $signed({4'b0, qb_ff});
            mul_cmd.base = c11_ff;
         end
         ST_C00: begin
            mul_cmd.op_a = $signed({{3{p00_ff[31]}}, p00_ff});
            mul_cmd.op_b = k0_ff;
            mul_cmd.base = p00_ff;
            mul_cmd.sub = 1'b1;
         end
         ST_C01: begin
            mul_cmd.op_a = $signed({{3{p01_ff[31]}}, p01_ff});
            mul_cmd.op_b = k0_ff;
            mul_cmd.base = p01_ff;
            mul_cmd.sub = 1'b1;
         end
         ST_C10: begin
            mul_cmd.op_a = $signed({{3{p00_ff[31]}}, p00_ff});
            mul_cmd.op_b = k1_ff;
            mul_cmd.base = p10_ff;
            mul_cmd.sub = 1'b1;
         end
         ST_C11: begin
            mul_cmd.op_a = $signed({{3{p01_ff[31]}}, p01_ff});
            mul_cmd.op_b = k1_ff;
            mul_cmd.base = p11_ff;
            mul_cmd.sub = 1'b1;
         end
         ST_BIAS: begin
            mul_cmd.op_a = err;
            mul_cmd.op_b = k1_ff;
            mul_cmd.base = bias_ff;
         end
         ST_ANGLE: begin
            mul_cmd.op_a = err;
            mul_cmd.op_b = k0_ff;
            mul_cmd.base = angle_ff;
         end
         default: begin
            mul_cmd.op_a = '0;
         end
      endcase

      div_cmd.start = (state_ff == SQ_ISSUE) && is_div;
      div_cmd.num = (step_ff == ST_GAIN0) ? p00_ff : p10_ff;
      div_cmd.den = $signed({2'b0, r_ff}) + $signed({p00_ff[31], p00_ff});
   end

   // Sequencer and write-back.
   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      accel_in = accel_ff;
      gyro_in = gyro_ff;
      angle_in = angle_ff;
      bias_in = bias_ff;
      c00_in = c00_ff;
      c01_in = c01_ff;
      c10_in = c10_ff;
      c11_in = c11_ff;
      p00_in = p00_ff;
      p01_in = p01_ff;
      p10_in = p10_ff;
      p11_in = p11_ff;
      k0_in = k0_ff;
      k1_in = k1_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in = rsp_tdata_ff;
      case (state_ff)
         SQ_IDLE: begin
            if (req_tvalid) begin
               accel_in = req_tdata[31:0];
               gyro_in = req_tdata[63:32];
               step_in = ST_ANGLE_PRED;
               state_in = SQ_ISSUE;
            end
         end
         SQ_ISSUE: begin
            state_in = SQ_WAIT;
         end
         SQ_WAIT: begin
            if (unit_done) begin
               case (step_ff)
                  ST_ANGLE_PRED: angle_in = mul_rsp.result;
                  ST_P00_PRED:   p00_in = mul_rsp.result;
                  ST_P01_PRED:   p01_in = mul_rsp.result;
                  ST_P10_PRED:   p10_in = mul_rsp.result;
                  ST_P11_PRED:   p11_in = mul_rsp.result;
                  ST_GAIN0:      k0_in = div_rsp.result;
                  ST_GAIN1:      k1_in = div_rsp.result;
                  ST_C00:        c00_in = mul_rsp.result;
                  ST_C01:        c01_in = mul_rsp.result;
                  ST_C10:        c10_in = mul_rsp.result;
                  ST_C11:        c11_in = mul_rsp.result;
                  ST_BIAS:       bias_in = mul_rsp.result;
                  ST_ANGLE:      angle_in = mul_rsp.result;
                  default:       angle_in = angle_ff;
               endcase
               if (step_ff == ST_ANGLE) begin
                  state_in = SQ_DONE;
               end else begin
                  step_in = step_type'(step_ff + 4'd1);
                  state_in = SQ_ISSUE;
               end
            end
         end
         SQ_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in = {rate, angle_ff};
               state_in = SQ_IDLE;
            end
         end
         default: begin
            state_in = SQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SQ_IDLE;
         step_ff <= ST_ANGLE_PRED;
         rsp_tvalid_ff <= 1'b0;
         angle_ff <= '0;
         bias_ff <= '0;
         c00_ff <= OneQ30;
         c01_ff <= '0;
         c10_ff <= '0;
         c11_ff <= OneQ30;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         angle_ff <= angle_in;
         bias_ff <= bias_in;
         c00_ff <= c00_in;
         c01_ff <= c01_in;
         c10_ff <= c10_in;
         c11_ff <= c11_in;
      end
   end

   always_ff @(posedge clock) begin
      accel_ff <= accel_in;
      gyro_ff <= gyro_in;
      p00_ff <= p00_in;
      p01_ff <= p01_in;
      p10_ff <= p10_in;
      p11_ff <= p11_in;
      k0_ff <= k0_in;
      k1_ff <= k1_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign req_tready = (state_ff == SQ_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = rsp_tdata_ff;

endmodule
